// ===== src/mbg_pkg.sv =====
// Shared types, codes and helper functions for the maze backtracker generator.
package mbg_pkg;

    // Item kinds on the command port.
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_STEP  = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    // Result action codes; codes below ACT_BACK are the carved direction.
    localparam logic [2:0] ACT_BACK = 3'd4;
    localparam logic [2:0] ACT_DONE = 3'd5;
    localparam logic [2:0] ACT_INFO = 3'd6;

    // Directions, in the order neighbours are examined.
    localparam logic [1:0] DIR_N = 2'd0;
    localparam logic [1:0] DIR_E = 2'd1;
    localparam logic [1:0] DIR_S = 2'd2;
    localparam logic [1:0] DIR_W = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    localparam int CFG_W = 6;
    localparam int RND_W = 16;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_PROBE,
        ST_TALLY,
        ST_PICK,
        ST_MOVE,
        ST_POP,
        ST_READ,
        ST_REPLY
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic restart;
        logic sweep;
        logic probe;
        logic pick;
        logic move;
        logic pop_rd;
        logic pop_ld;
        logic finish;
        logic rd_cell;
        logic respond;
    } ctrl_cmd_t;

    typedef struct packed {
        logic sweep_last;
        logic probe_last;
        logic finished;
        logic has_move;
        logic stack_empty;
    } dp_stat_t;

    // Remainder of a 16-bit word by three: base-4 digits are summed twice,
    // since four is one more than a multiple of three.
    function automatic logic [1:0] mod3_16(input logic [RND_W-1:0] v);
        logic [4:0] s1;
        logic [2:0] s2;
        logic [1:0] r;
        s1 = 5'd0;
        for (int i = 0; i < RND_W / 2; i++)
        begin
            s1 = s1 + {3'd0, v[2*i +: 2]};
        end
        s2 = {1'b0, s1[1:0]} + {1'b0, s1[3:2]} + {2'd0, s1[4]};
        case (s2)
            3'd0, 3'd3, 3'd6: r = 2'd0;
            3'd1, 3'd4, 3'd7: r = 2'd1;
            default:          r = 2'd2;
        endcase
        return r;
    endfunction

endpackage

// ===== src/maze_backtracker_generator_unit.sv =====
// Top level of the maze backtracker generator: controller, datapath and checks.
//
// Words are accepted when start is high and busy is low, and each gives one
// result word on the done strobe, which the receiver cannot hold off. A step
// word runs through the probe, tally, pick and move states (and a pop state
// when it backtracks) before the reply: the four neighbour visited bits are
// read one per cycle from the single read port of the visited map, then the
// choice and the move are made in turn. A step after the maze is finished
// goes straight to the reply, and a read word passes through a read state
// first. A start word rewrites every cell of the wall and visited memories,
// one cell per cycle, before its reply. The same clearing pass, without a
// result, runs after reset, and busy stays high until it ends. Configuration
// writes are always taken and must only be made while the block is idle.
module maze_backtracker_generator_unit #(
    parameter int MAX_ROWS = 32,
    parameter int MAX_COLS = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  kind,
    input  logic [mbg_pkg::RND_W-1:0]   random_word,
    input  logic [4:0]                  read_row,
    input  logic [4:0]                  read_col,
    output logic                        done,
    output logic [2:0]                  action,
    output logic [4:0]                  cur_row,
    output logic [4:0]                  cur_col,
    output logic [3:0]                  cell_walls,
    output logic                        cell_visited,
    output logic                        maze_done,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        cfg_index,
    input  logic [mbg_pkg::CFG_W-1:0]   cfg_data
);

    mbg_pkg::ctrl_cmd_t cmd;
    mbg_pkg::dp_stat_t  stat;

    assign cfg_ready = 1'b1;

    mbg_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .kind  (kind),
        .stat  (stat),
        .busy  (busy),
        .cmd   (cmd)
    );

    mbg_datapath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .kind         (kind),
        .random_word  (random_word),
        .read_row     (read_row),
        .read_col     (read_col),
        .cmd          (cmd),
        .stat         (stat),
        .done         (done),
        .action       (action),
        .cur_row      (cur_row),
        .cur_col      (cur_col),
        .cell_walls   (cell_walls),
        .cell_visited (cell_visited),
        .maze_done    (maze_done)
    );

    // A result word only ever follows a cycle in which the block was busy.
    a_done_after_busy : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a word in progress");

    // An accepted word always takes the block out of idle.
    a_accept_busy : assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not make the block busy");

    // A finished report always comes with the finished flag.
    a_finished_flag : assert property (@(posedge clk) disable iff (!rst_n)
        (done && (action == mbg_pkg::ACT_DONE)) |-> maze_done)
        else $error("finished action without maze_done");

    // A carving step can never happen on a finished maze.
    a_carve_not_done : assert property (@(posedge clk) disable iff (!rst_n)
        (done && (action < mbg_pkg::ACT_BACK)) |-> !maze_done)
        else $error("carved a wall after the maze was finished");

endmodule

// ===== src/mbg_ctrl.sv =====
// Controller state machine that sequences start, step and read words.
module mbg_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [1:0]          kind,
    input  mbg_pkg::dp_stat_t   stat,
    output logic                busy,
    output mbg_pkg::ctrl_cmd_t  cmd
);

    mbg_pkg::ctrl_state_t state_reg;
    mbg_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mbg_pkg::ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != mbg_pkg::ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            mbg_pkg::ST_INIT:
            begin
                cmd.sweep = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = mbg_pkg::ST_IDLE;
                end
            end
            mbg_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    case (kind)
                        mbg_pkg::KIND_START:
                        begin
                            cmd.restart = 1'b1;
                            state_next  = mbg_pkg::ST_CLEAR;
                        end
                        mbg_pkg::KIND_STEP:
                        begin
                            if (stat.finished)
                            begin
                                cmd.finish = 1'b1;
                                state_next = mbg_pkg::ST_REPLY;
                            end
                            else
                            begin
                                state_next = mbg_pkg::ST_PROBE;
                            end
                        end
                        mbg_pkg::KIND_READ:
                        begin
                            state_next = mbg_pkg::ST_READ;
                        end
                        default:
                        begin
                            state_next = mbg_pkg::ST_REPLY;
                        end
                    endcase
                end
            end
            mbg_pkg::ST_CLEAR:
            begin
                cmd.sweep = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = mbg_pkg::ST_REPLY;
                end
            end
            mbg_pkg::ST_PROBE:
            begin
                cmd.probe = 1'b1;
                if (stat.probe_last)
                begin
                    state_next = mbg_pkg::ST_TALLY;
                end
            end
            mbg_pkg::ST_TALLY:
            begin
                // The last neighbour's visited bit lands in this cycle.
                state_next = mbg_pkg::ST_PICK;
            end
            mbg_pkg::ST_PICK:
            begin
                cmd.pick   = 1'b1;
                state_next = mbg_pkg::ST_MOVE;
            end
            mbg_pkg::ST_MOVE:
            begin
                if (stat.has_move)
                begin
                    cmd.move   = 1'b1;
                    state_next = mbg_pkg::ST_REPLY;
                end
                else if (!stat.stack_empty)
                begin
                    cmd.pop_rd = 1'b1;
                    state_next = mbg_pkg::ST_POP;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    state_next = mbg_pkg::ST_REPLY;
                end
            end
            mbg_pkg::ST_POP:
            begin
                cmd.pop_ld = 1'b1;
                state_next = mbg_pkg::ST_REPLY;
            end
            mbg_pkg::ST_READ:
            begin
                cmd.rd_cell = 1'b1;
                state_next  = mbg_pkg::ST_REPLY;
            end
            mbg_pkg::ST_REPLY:
            begin
                cmd.respond = 1'b1;
                state_next  = mbg_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = mbg_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/mbg_datapath.sv =====
// Datapath: cell memories, path stack, walk position and result registers.
module mbg_datapath #(
    parameter int MAX_ROWS = 32,
    parameter int MAX_COLS = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    input  logic                        cfg_index,
    input  logic [mbg_pkg::CFG_W-1:0]   cfg_data,
    input  logic [1:0]                  kind,
    input  logic [mbg_pkg::RND_W-1:0]   random_word,
    input  logic [4:0]                  read_row,
    input  logic [4:0]                  read_col,
    input  mbg_pkg::ctrl_cmd_t          cmd,
    output mbg_pkg::dp_stat_t           stat,
    output logic                        done,
    output logic [2:0]                  action,
    output logic [4:0]                  cur_row,
    output logic [4:0]                  cur_col,
    output logic [3:0]                  cell_walls,
    output logic                        cell_visited,
    output logic                        maze_done
);

    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int AW    = RW + CW;
    localparam int DEPTH = 1 << AW;
    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int SPW   = AW + 1;
    localparam int SPANW = (RW > CW) ? RW + 1 : CW + 1;
    localparam int CNTW  = (SPANW > mbg_pkg::CFG_W) ? SPANW : mbg_pkg::CFG_W;

    // Configuration and walk state.
    logic [mbg_pkg::CFG_W-1:0] rows_cfg_reg;
    logic [mbg_pkg::CFG_W-1:0] cols_cfg_reg;
    logic [RW-1:0]             row_reg;
    logic [CW-1:0]             col_reg;
    logic [SPW-1:0]            sp_reg;
    logic                      finished_reg;
    logic [AW-1:0]             sweep_cnt_reg;
    logic [1:0]                probe_cnt_reg;
    logic                      probe_v_reg;
    logic [1:0]                probe_dir_reg;
    logic                      done_reg;

    // Latched item fields and working values.
    logic [1:0]                kind_reg;
    logic [mbg_pkg::RND_W-1:0] rnd_reg;
    logic [AW-1:0]             cell_addr_reg;
    logic                      rd_ok_reg;
    logic [3:0]                cand_reg;
    logic [1:0]                dir_reg;
    logic                      move_reg;
    logic [2:0]                act_reg;
    logic                      vis_rd_reg;
    logic [3:0]                wall_rd_reg;
    logic [AW-1:0]             stack_rd_reg;

    logic [2:0]                action_reg;
    logic [4:0]                cur_row_reg;
    logic [4:0]                cur_col_reg;
    logic [3:0]                cell_walls_reg;
    logic                      cell_visited_reg;
    logic                      maze_done_reg;

    logic [CNTW-1:0] rows_eff;
    logic [CNTW-1:0] cols_eff;
    logic [CNTW-1:0] r_ext;
    logic [CNTW-1:0] c_ext;
    logic [3:0]      nb_ok;
    logic [AW-1:0]   nb_addr [4];
    logic [AW-1:0]   here_addr;
    logic [AW-1:0]   there_addr;
    logic [AW-1:0]   rd_addr;
    logic [1:0]      opp_dir;
    logic [2:0]      cand_cnt;
    logic [1:0]      pick_idx;
    logic [1:0]      sel_dir;
    logic [SPW-1:0]  sp_m1;
    logic            push_ok;
    logic            vis_we;
    logic [AW-1:0]   vis_waddr;
    logic            vis_wdata;

    logic            vis_mem   [DEPTH];
    logic [AW-1:0]   stack_mem [DEPTH];

    // Counts of zero act as one; counts beyond the storage saturate.
    always_comb
    begin
        if (rows_cfg_reg == '0)
        begin
            rows_eff = CNTW'(1);
        end
        else if (CNTW'(rows_cfg_reg) > CNTW'(MAX_ROWS))
        begin
            rows_eff = CNTW'(MAX_ROWS);
        end
        else
        begin
            rows_eff = CNTW'(rows_cfg_reg);
        end
        if (cols_cfg_reg == '0)
        begin
            cols_eff = CNTW'(1);
        end
        else if (CNTW'(cols_cfg_reg) > CNTW'(MAX_COLS))
        begin
            cols_eff = CNTW'(MAX_COLS);
        end
        else
        begin
            cols_eff = CNTW'(cols_cfg_reg);
        end
    end

    assign r_ext = CNTW'(row_reg);
    assign c_ext = CNTW'(col_reg);

    // A neighbour counts only if it lies inside the active grid; the walk
    // itself may sit outside it after the counts have been lowered.
    assign nb_ok[mbg_pkg::DIR_N] = (row_reg != '0) && ((r_ext - CNTW'(1)) < rows_eff)
                                   && (c_ext < cols_eff);
    assign nb_ok[mbg_pkg::DIR_E] = (r_ext < rows_eff) && ((c_ext + CNTW'(1)) < cols_eff);
    assign nb_ok[mbg_pkg::DIR_S] = ((r_ext + CNTW'(1)) < rows_eff) && (c_ext < cols_eff);
    assign nb_ok[mbg_pkg::DIR_W] = (col_reg != '0) && ((c_ext - CNTW'(1)) < cols_eff)
                                   && (r_ext < rows_eff);

    assign here_addr                = {row_reg, col_reg};
    assign nb_addr[mbg_pkg::DIR_N]  = {row_reg - RW'(1), col_reg};
    assign nb_addr[mbg_pkg::DIR_E]  = {row_reg, col_reg + CW'(1)};
    assign nb_addr[mbg_pkg::DIR_S]  = {row_reg + RW'(1), col_reg};
    assign nb_addr[mbg_pkg::DIR_W]  = {row_reg, col_reg - CW'(1)};
    assign there_addr               = nb_addr[dir_reg];
    assign opp_dir                  = dir_reg + 2'd2;

    assign rd_addr = cmd.rd_cell ? cell_addr_reg : nb_addr[probe_cnt_reg];

    assign sp_m1   = sp_reg - SPW'(1);
    assign push_ok = (sp_reg < SPW'(CELLS));

    // Candidate count and the chosen one, in N, E, S, W order.
    always_comb
    begin
        logic [2:0] seen;
        logic       found;
        cand_cnt = 3'd0;
        for (int i = 0; i < 4; i++)
        begin
            cand_cnt = cand_cnt + {2'd0, cand_reg[i]};
        end
        case (cand_cnt)
            3'd2:    pick_idx = {1'b0, rnd_reg[0]};
            3'd3:    pick_idx = mbg_pkg::mod3_16(rnd_reg);
            3'd4:    pick_idx = rnd_reg[1:0];
            default: pick_idx = 2'd0;
        endcase
        seen    = 3'd0;
        found   = 1'b0;
        sel_dir = mbg_pkg::DIR_N;
        for (int i = 0; i < 4; i++)
        begin
            if (cand_reg[i])
            begin
                if (!found && (seen == {1'b0, pick_idx}))
                begin
                    sel_dir = 2'(i);
                    found   = 1'b1;
                end
                seen = seen + 3'd1;
            end
        end
    end

    // Visited map: the sweep restores the cleared state, a move marks the
    // new cell.
    assign vis_we    = cmd.sweep | cmd.move;
    assign vis_waddr = cmd.sweep ? sweep_cnt_reg : there_addr;
    assign vis_wdata = cmd.sweep ? (sweep_cnt_reg == '0) : 1'b1;

    always_ff @(posedge clk)
    begin
        if (vis_we)
        begin
            vis_mem[vis_waddr] <= vis_wdata;
        end
        vis_rd_reg <= vis_mem[rd_addr];
    end

    // One wall bank per direction, so that both sides of a carved wall are
    // cleared in the same cycle.
    for (genvar b = 0; b < 4; b++)
    begin : g_wall_bank
        logic          bank_mem [DEPTH];
        logic          bank_we;
        logic [AW-1:0] bank_waddr;

        assign bank_we    = cmd.sweep
                            | (cmd.move & ((dir_reg == 2'(b)) | (opp_dir == 2'(b))));
        assign bank_waddr = cmd.sweep ? sweep_cnt_reg
                            : ((dir_reg == 2'(b)) ? here_addr : there_addr);

        always_ff @(posedge clk)
        begin
            if (bank_we)
            begin
                bank_mem[bank_waddr] <= cmd.sweep;
            end
            wall_rd_reg[b] <= bank_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.move && push_ok)
        begin
            stack_mem[sp_reg[AW-1:0]] <= here_addr;
        end
        stack_rd_reg <= stack_mem[sp_m1[AW-1:0]];
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_cfg_reg  <= mbg_pkg::CFG_W'(15);
            cols_cfg_reg  <= mbg_pkg::CFG_W'(15);
            row_reg       <= '0;
            col_reg       <= '0;
            sp_reg        <= '0;
            finished_reg  <= 1'b0;
            sweep_cnt_reg <= '0;
            probe_cnt_reg <= 2'd0;
            probe_v_reg   <= 1'b0;
            probe_dir_reg <= 2'd0;
            done_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    mbg_pkg::CFG_ROWS: rows_cfg_reg <= cfg_data;
                    mbg_pkg::CFG_COLS: cols_cfg_reg <= cfg_data;
                    default:           rows_cfg_reg <= rows_cfg_reg;
                endcase
            end
            if (cmd.sweep)
            begin
                sweep_cnt_reg <= sweep_cnt_reg + AW'(1);
            end
            if (cmd.load)
            begin
                probe_cnt_reg <= 2'd0;
            end
            else if (cmd.probe)
            begin
                probe_cnt_reg <= probe_cnt_reg + 2'd1;
            end
            probe_v_reg   <= cmd.probe;
            probe_dir_reg <= probe_cnt_reg;
            done_reg      <= cmd.respond;
            if (cmd.restart)
            begin
                row_reg      <= '0;
                col_reg      <= '0;
                sp_reg       <= '0;
                finished_reg <= 1'b0;
            end
            if (cmd.move)
            begin
                row_reg <= there_addr[AW-1:CW];
                col_reg <= there_addr[CW-1:0];
                if (push_ok)
                begin
                    sp_reg <= sp_reg + SPW'(1);
                end
            end
            if (cmd.pop_rd)
            begin
                sp_reg <= sp_m1;
            end
            if (cmd.pop_ld)
            begin
                row_reg <= stack_rd_reg[AW-1:CW];
                col_reg <= stack_rd_reg[CW-1:0];
            end
            if (cmd.finish)
            begin
                finished_reg <= 1'b1;
            end
        end
    end

    // Working values and results.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg      <= kind;
            rnd_reg       <= random_word;
            cell_addr_reg <= {RW'(read_row), CW'(read_col)};
            rd_ok_reg     <= (32'(read_row) < 32'(MAX_ROWS))
                             && (32'(read_col) < 32'(MAX_COLS));
            cand_reg      <= 4'd0;
        end
        if (probe_v_reg)
        begin
            cand_reg[probe_dir_reg] <= nb_ok[probe_dir_reg] & ~vis_rd_reg;
        end
        if (cmd.pick)
        begin
            dir_reg  <= sel_dir;
            move_reg <= (cand_reg != 4'd0);
        end
        // A step on a finished maze loads and finishes in the same cycle.
        if (cmd.finish)
        begin
            act_reg <= mbg_pkg::ACT_DONE;
        end
        else if (cmd.pop_ld)
        begin
            act_reg <= mbg_pkg::ACT_BACK;
        end
        else if (cmd.move)
        begin
            act_reg <= {1'b0, dir_reg};
        end
        else if (cmd.load)
        begin
            act_reg <= mbg_pkg::ACT_INFO;
        end
        if (cmd.respond)
        begin
            action_reg    <= act_reg;
            cur_row_reg   <= 5'(row_reg);
            cur_col_reg   <= 5'(col_reg);
            maze_done_reg <= finished_reg;
            if ((kind_reg == mbg_pkg::KIND_READ) && rd_ok_reg)
            begin
                cell_walls_reg   <= wall_rd_reg;
                cell_visited_reg <= vis_rd_reg;
            end
            else
            begin
                cell_walls_reg   <= 4'd0;
                cell_visited_reg <= 1'b0;
            end
        end
    end

    assign stat.sweep_last  = (sweep_cnt_reg == {AW{1'b1}});
    assign stat.probe_last  = (probe_cnt_reg == 2'd3);
    assign stat.finished    = finished_reg;
    assign stat.has_move    = move_reg;
    assign stat.stack_empty = (sp_reg == '0);

    assign done         = done_reg;
    assign action       = action_reg;
    assign cur_row      = cur_row_reg;
    assign cur_col      = cur_col_reg;
    assign cell_walls   = cell_walls_reg;
    assign cell_visited = cell_visited_reg;
    assign maze_done    = maze_done_reg;

endmodule
